@@ hdl/xkh_pkg.sv @@
// ----------------------------------------------------------------------------
// xkh_pkg: shared types and helpers for the XOR key hex codec
// Result word layout, status codes, register indexes and hex conversions.
// ----------------------------------------------------------------------------
`default_nettype none

package xkh_pkg;

  // Key length in bytes; the message position wraps here (positions 0 to 15)
  localparam int KEY_BYTES = 16;
  // Position counter width, enough to address all 16 key bytes
  localparam int POS_W = 4;
  localparam int KEY_W = 64;
  localparam int IDX_W = 2;

  // Register indexes on the write port
  localparam logic [IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_UPPER = 2'd2;

  // Mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_DIGIT  = 2'd1,
    STATUS_ODD_LENGTH = 2'd2
  } status_t;

  // One accepted input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_message;
    logic       end_of_message;
  } item_t;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    status_t    status;
    logic       message_done;
  } result_t;

  // Results produced by one input word (zero, one or two)
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } batch_t;

  // Nibble to lowercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h57 + wide;
    end
  endfunction

  // Hex character (either case) to nibble; bit 4 set marks a non-hex character
  function automatic logic [4:0] char_to_nibble(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    char_to_nibble = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      char_to_nibble = {1'b0, diff[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      char_to_nibble = {1'b0, diff[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      char_to_nibble = {1'b0, diff[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/xkh_core.sv @@
// ----------------------------------------------------------------------------
// xkh_core: message state and per-word coding logic
// Computes the results of one input word and updates the message state.
// ----------------------------------------------------------------------------
`default_nettype none

module xkh_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire xkh_pkg::item_t            item,
  input  wire logic                      mode,
  input  wire logic [xkh_pkg::KEY_W-1:0] key_lower,
  input  wire logic [xkh_pkg::KEY_W-1:0] key_upper,
  output xkh_pkg::batch_t                batch
);
  import xkh_pkg::*;

  logic [POS_W-1:0] key_position, key_position_next;
  logic [3:0]       held_high_nibble, held_high_nibble_next;
  logic             nibble_pending, nibble_pending_next;
  logic             message_failed, message_failed_next;

  logic [POS_W-1:0]   pos_cur;
  logic [3:0]         held_cur;
  logic               pending_cur;
  logic               failed_cur;
  logic [2*KEY_W-1:0] key_all;
  logic [7:0]         pad;
  logic [POS_W:0]     pos_inc;
  logic [POS_W-1:0]   pos_adv;
  logic [7:0]         coded;
  logic [7:0]         rebuilt;
  logic [4:0]         digit;

  // Start of message clears the state before this word
  always_comb begin
    pos_cur     = item.first_of_message ? '0 : key_position;
    held_cur    = item.first_of_message ? '0 : held_high_nibble;
    pending_cur = item.first_of_message ? 1'b0 : nibble_pending;
    failed_cur  = item.first_of_message ? 1'b0 : message_failed;
  end

  // Pad byte is the complement of the key byte at the current position
  assign key_all = {key_upper, key_lower};
  assign pad     = ~key_all[{pos_cur, 3'b000} +: 8];

  // Advance and wrap the position at the key length
  assign pos_inc = {1'b0, pos_cur} + (POS_W+1)'(1);
  assign pos_adv = (pos_inc >= (POS_W+1)'(KEY_BYTES)) ? '0 : pos_inc[POS_W-1:0];

  assign coded   = item.data_byte ^ pad;
  assign digit   = char_to_nibble(item.data_byte);
  assign rebuilt = {held_cur, digit[3:0]} ^ pad;

  // Results and next state for the word at hand
  always_comb begin
    batch                 = '0;
    batch.first.status    = STATUS_OK;
    batch.second.status   = STATUS_OK;
    key_position_next     = pos_cur;
    held_high_nibble_next = held_cur;
    nibble_pending_next   = pending_cur;
    message_failed_next   = failed_cur;

    if (failed_cur) begin
      batch.count = 2'd0;
    end else if (mode == MODE_ENCODE) begin
      // Two lowercase hex characters, high nibble first
      batch.count               = 2'd2;
      batch.first.out_byte      = hex_char(coded[7:4]);
      batch.second.out_byte     = hex_char(coded[3:0]);
      batch.second.last_of_run  = 1'b1;
      batch.second.message_done = item.end_of_message;
      key_position_next         = pos_adv;
    end else if (digit[4]) begin
      // Non-hex character fails the rest of the message
      batch.count              = 2'd1;
      batch.first.last_of_run  = 1'b1;
      batch.first.status       = STATUS_BAD_DIGIT;
      batch.first.message_done = 1'b1;
      message_failed_next      = 1'b1;
    end else if (!pending_cur) begin
      // Hold the high nibble; a lone nibble at message end is an error
      held_high_nibble_next = digit[3:0];
      nibble_pending_next   = 1'b1;
      if (item.end_of_message) begin
        batch.count              = 2'd1;
        batch.first.last_of_run  = 1'b1;
        batch.first.status       = STATUS_ODD_LENGTH;
        batch.first.message_done = 1'b1;
      end
    end else begin
      // Low nibble completes the byte
      batch.count              = 2'd1;
      batch.first.out_byte     = rebuilt;
      batch.first.last_of_run  = 1'b1;
      batch.first.message_done = item.end_of_message;
      key_position_next        = pos_adv;
      held_high_nibble_next    = '0;
      nibble_pending_next      = 1'b0;
    end

    // Message end returns all state to zero
    if (item.end_of_message) begin
      key_position_next     = '0;
      held_high_nibble_next = '0;
      nibble_pending_next   = 1'b0;
      message_failed_next   = 1'b0;
    end
  end

  // Commit the state when the word is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      key_position     <= '0;
      held_high_nibble <= '0;
      nibble_pending   <= 1'b0;
      message_failed   <= 1'b0;
    end else if (fire) begin
      key_position     <= key_position_next;
      held_high_nibble <= held_high_nibble_next;
      nibble_pending   <= nibble_pending_next;
      message_failed   <= message_failed_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/xkh_out.sv @@
// ----------------------------------------------------------------------------
// xkh_out: result register with a second-result holding slot
// Takes up to two results per processed word and sends one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module xkh_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire xkh_pkg::batch_t  batch,
  input  wire logic             out_stall,
  output logic                  room,
  output logic                  out_valid,
  output xkh_pkg::result_t      result
);
  import xkh_pkg::*;

  result_t held;
  logic    held_valid;
  logic    out_take;

  assign out_take = out_valid && !out_stall;
  // New batch fits only when the holding slot is empty and the output frees up
  assign room     = !held_valid && (!out_valid || out_take);

  // Control: output and holding slot valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else if (held_valid) begin
      if (!out_valid || out_take) begin
        out_valid  <= 1'b1;
        held_valid <= 1'b0;
      end
    end else if (push && batch.count != 2'd0) begin
      out_valid  <= 1'b1;
      held_valid <= (batch.count == 2'd2);
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: load the output word and the second result
  always_ff @(posedge clk) begin
    if (held_valid) begin
      if (!out_valid || out_take) begin
        result <= held;
      end
    end else if (push && batch.count != 2'd0) begin
      result <= batch.first;
      held   <= batch.second;
    end
  end

endmodule

`default_nettype wire

@@ hdl/xor_key_hex_codec.sv @@
// ----------------------------------------------------------------------------
// xor_key_hex_codec: repeating key XOR codec with hex text
// Top level: register port, input register, coding core and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one byte per word with
//   message start and end flags. Output channel (out_valid / out_stall)
//   carries one result word per cycle while not stalled. Both sides hold
//   valid and payload while stalled.
//   Registers mode, key_lower and key_upper are written through wr_en,
//   wr_index and wr_data; the user must do so only while the block is
//   idle, as the block does not enforce this. An accepted word waits in
//   the input register, is coded by the core and its first result is
//   loaded into the result register, which sends one word per cycle
//   while not stalled; encode gives two hex characters per byte and
//   decode gives one byte per pair of hex characters.
//   A stalled output holds its word; a second result waits in a holding
//   slot and the input register then stalls the input side.
//   Reset clears the registers, the message state and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_key_hex_codec (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [xkh_pkg::IDX_W-1:0] wr_index,
  input  wire logic [xkh_pkg::KEY_W-1:0] wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      first_of_message,
  input  wire logic                      end_of_message,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           last_of_run,
  output logic [1:0]                     status,
  output logic                           message_done
);
  import xkh_pkg::*;

  logic             mode;
  logic [KEY_W-1:0] key_lower;
  logic [KEY_W-1:0] key_upper;

  item_t   item;
  logic    item_valid;
  logic    fire;
  logic    room;
  logic    in_take;
  batch_t  batch;
  result_t result;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ENCODE;
      key_lower <= '0;
      key_upper <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:      mode      <= wr_data[0];
        REG_KEY_LOWER: key_lower <= wr_data;
        REG_KEY_UPPER: key_upper <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register: refill in the same cycle the held word is processed
  assign fire     = item_valid && room;
  assign in_stall = item_valid && !room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.data_byte        <= data_byte;
      item.first_of_message <= first_of_message;
      item.end_of_message   <= end_of_message;
    end
  end

  xkh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .mode      (mode),
    .key_lower (key_lower),
    .key_upper (key_upper),
    .batch     (batch)
  );

  xkh_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .batch     (batch),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_byte     = result.out_byte;
  assign last_of_run  = result.last_of_run;
  assign status       = result.status;
  assign message_done = result.message_done;

endmodule

`default_nettype wire

@@ hdl/xkh_checker.sv @@
// ----------------------------------------------------------------------------
// xkh_checker: port-level checks for the XOR key hex codec
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xkh_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run,
  input wire logic [1:0] status,
  input wire logic       message_done
);
  import xkh_pkg::*;

  // Hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result word changed");

  // Error words are single, zero and close the message
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> last_of_run && message_done && out_byte == 8'd0)
    else $error("error word malformed");

  // Message end only on the last word of a run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> last_of_run)
    else $error("message end before last word of run");

  // A leading word is the high hex character of an encoded byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> status == STATUS_OK &&
      ((out_byte >= 8'h30 && out_byte <= 8'h39) || (out_byte >= 8'h61 && out_byte <= 8'h66)))
    else $error("leading word is not a lowercase hex character");

endmodule

bind xor_key_hex_codec xkh_checker u_xkh_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .last_of_run  (last_of_run),
  .status       (status),
  .message_done (message_done)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the XOR key hex codec
// Drives byte and hex-text messages under random idle and stall patterns.
// A built-in codec model predicts each result word, and every accepted
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import xkh_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                wr_en = 1'b0;
  logic [IDX_W-1:0]    wr_index = '0;
  logic [KEY_W-1:0]    wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'd0;
  logic                first_of_message = 1'b0;
  logic                end_of_message = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;
  logic [1:0]          status;
  logic                message_done;

  // Codec model: registers and message state
  logic                cfg_mode;
  logic [KEY_W-1:0]    cfg_key_lo;
  logic [KEY_W-1:0]    cfg_key_hi;
  logic [3:0]          msg_pos;
  logic [3:0]          msg_high_nib;
  logic                msg_nib_held;
  logic                msg_failed;

  result_t             coded_q[$];
  int                  fail_count = 0;
  int                  live_words = 0;
  int                  stall_left = 0;
  bit                  tx_jitter = 1'b0;
  bit                  rx_jitter = 1'b0;

  xor_key_hex_codec dut (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .end_of_message   (end_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .last_of_run      (last_of_run),
    .status           (status),
    .message_done     (message_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #600000;
    $display("Simulation FAILED");
    $finish;
  end

  // Pad is the complement of the key byte at the current position
  function automatic logic [7:0] pad_at(input logic [3:0] p);
    logic [KEY_W-1:0] w;
    w = p[3] ? cfg_key_hi : cfg_key_lo;
    return ~w[p[2:0]*8 +: 8];
  endfunction

  function automatic logic [7:0] hex_text(input logic [3:0] n, input bit upper);
    if (n < 4'd10) begin
      return 8'd48 + {4'd0, n};
    end
    return (upper ? 8'd55 : 8'd87) + {4'd0, n};
  endfunction

  // Returns 16 for a character outside 0-9, a-f, A-F
  function automatic logic [4:0] text_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - 8'd48)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - 8'd87)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - 8'd55)};
    return 5'd16;
  endfunction

  function automatic result_t make_result(input logic [7:0] b, input logic last,
                                          input status_t st, input logic done);
    result_t r;
    r.out_byte     = b;
    r.last_of_run  = last;
    r.status       = st;
    r.message_done = done;
    return r;
  endfunction

  // Append one predicted result word
  function automatic void queue_word(input result_t r);
    coded_q.insert(coded_q.size(), r);
  endfunction

  task automatic clear_message();
    msg_pos      = 4'd0;
    msg_high_nib = 4'd0;
    msg_nib_held = 1'b0;
    msg_failed   = 1'b0;
  endtask

  task automatic step_position();
    int nxt;
    nxt = int'(msg_pos) + 1;
    msg_pos = (nxt >= KEY_BYTES) ? 4'd0 : 4'(nxt);
  endtask

  // Work out the result words of one accepted word and queue them
  task automatic xor_hex_predict(input logic [7:0] b, input logic sof, input logic eof);
    logic [7:0] v;
    logic [4:0] nib;
    if (sof) clear_message();
    if (!msg_failed) begin
      live_words++;
      if (cfg_mode == MODE_ENCODE) begin
        v = b ^ pad_at(msg_pos);
        step_position();
        queue_word(make_result(hex_text(v[7:4], 1'b0), 1'b0, STATUS_OK, 1'b0));
        queue_word(make_result(hex_text(v[3:0], 1'b0), 1'b1, STATUS_OK, eof));
      end else begin
        nib = text_nibble(b);
        if (nib[4]) begin
          queue_word(make_result(8'd0, 1'b1, STATUS_BAD_DIGIT, 1'b1));
          msg_failed = 1'b1;
        end else if (!msg_nib_held) begin
          msg_high_nib = nib[3:0];
          msg_nib_held = 1'b1;
          if (eof) queue_word(make_result(8'd0, 1'b1, STATUS_ODD_LENGTH, 1'b1));
        end else begin
          v = {msg_high_nib, nib[3:0]} ^ pad_at(msg_pos);
          step_position();
          msg_nib_held = 1'b0;
          msg_high_nib = 4'd0;
          queue_word(make_result(v, 1'b1, STATUS_OK, eof));
        end
      end
    end
    if (eof) clear_message();
  endtask

  // Result side: check each accepted word, then draw the next stall
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coded_q.size() == 0) begin
          $display("%0t: unexpected result, got byte %02h status %0d", $time,
                   out_byte, status);
          fail_count++;
        end else begin
          want = coded_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, out_byte);
            fail_count++;
          end
          if (last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b", $time, want.last_of_run,
                     last_of_run);
            fail_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            fail_count++;
          end
          if (message_done !== want.message_done) begin
            $display("%0t: message_done expected %0b got %0b", $time, want.message_done,
                     message_done);
            fail_count++;
          end
        end
        stall_left = rx_jitter ? $urandom_range(0, 3) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Send one word; valid stays high into the next word when no gap is drawn
  task automatic send_word(input logic [7:0] b, input logic sof, input logic eof);
    int gap;
    gap = tx_jitter ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    data_byte        <= b;
    first_of_message <= sof;
    end_of_message   <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    xor_hex_predict(b, sof, eof);
  endtask

  // Hold off input until every queued result has come, then let the core settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic m, input logic [KEY_W-1:0] lo,
                          input logic [KEY_W-1:0] hi);
    logic [KEY_W-1:0] mode_word;
    wait_quiet();
    mode_word = {$urandom, $urandom};
    mode_word[0] = m;
    wr_en <= 1'b1;
    wr_index <= REG_MODE;
    wr_data <= mode_word;
    @(posedge clk);
    cfg_mode = m;
    wr_index <= REG_KEY_LOWER;
    wr_data <= lo;
    @(posedge clk);
    cfg_key_lo = lo;
    wr_index <= REG_KEY_UPPER;
    wr_data <= hi;
    @(posedge clk);
    cfg_key_hi = hi;
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Registers at their reset values: all-zero key, encode
  task automatic test_reset_defaults();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h3C, 1'b0, 1'b1);
  endtask

  // Encode extremes, a one-word message and a restart inside a message
  task automatic test_encode_extremes();
    set_regs(MODE_ENCODE, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    rx_jitter = 1'b1;
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b0);
    send_word(8'h01, 1'b0, 1'b1);
    send_word(8'h5A, 1'b1, 1'b1);
    send_word(8'h77, 1'b1, 1'b0);
    send_word(8'h10, 1'b0, 1'b0);
    send_word(8'h22, 1'b1, 1'b1);
  endtask

  // Decode pairs in both cases, an odd length and a bad digit
  task automatic test_decode_cases();
    set_regs(MODE_DECODE, 64'hA5A5_0000_FFFF_1234, 64'h0F0F_8000_0001_C3C3);
    tx_jitter = 1'b1;
    send_word("a", 1'b1, 1'b0);
    send_word("F", 1'b0, 1'b0);
    send_word("0", 1'b0, 1'b0);
    send_word("9", 1'b0, 1'b0);
    send_word("A", 1'b0, 1'b0);
    send_word("f", 1'b0, 1'b1);
    send_word("7", 1'b1, 1'b1);
    // bad digit closes the message; the rest is dropped
    send_word("1", 1'b1, 1'b0);
    send_word("G", 1'b0, 1'b0);
    send_word("2", 1'b0, 1'b0);
    send_word("3", 1'b0, 1'b1);
  endtask

  // Mode flip mid-message: the held nibble and the position survive encode
  task automatic test_mode_switch();
    set_regs(MODE_DECODE, 64'h1122334455667788, 64'h99AABBCCDDEEFF00);
    send_word("4", 1'b1, 1'b0);
    set_regs(MODE_ENCODE, cfg_key_lo, cfg_key_hi);
    send_word(8'h11, 1'b0, 1'b0);
    set_regs(MODE_DECODE, cfg_key_lo, cfg_key_hi);
    send_word("2", 1'b0, 1'b1);
  endtask

  task automatic random_message();
    int len;
    int k;
    bit lead;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
    if (cfg_mode == MODE_DECODE) begin
      len = len * 2 - (($urandom_range(0, 7) == 0) ? 1 : 0);
    end
    lead = ($urandom_range(0, 9) != 0);
    for (k = 0; k < len; k++) begin
      if (cfg_mode == MODE_ENCODE || $urandom_range(0, 39) == 0) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = hex_text(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      send_word(b, (k == 0 && lead) || $urandom_range(0, 63) == 0, k == len - 1);
    end
  endtask

  // Phases over modes and keys; random words until enough are coded
  task automatic test_random_traffic();
    int ph;
    int goal;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    for (ph = 0; live_words < 650; ph++) begin
      case (ph % 4)
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      set_regs(ph[0] ? MODE_DECODE : MODE_ENCODE, lo, hi);
      tx_jitter = (ph % 3 != 2);
      rx_jitter = (ph % 5 != 4);
      goal = live_words + 80;
      while (live_words < goal && live_words < 650) begin
        random_message();
        if ($urandom_range(0, 5) == 0) wait_quiet();
      end
    end
  endtask

  initial begin
    cfg_mode   = MODE_ENCODE;
    cfg_key_lo = '0;
    cfg_key_hi = '0;
    clear_message();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_encode_extremes();
    test_decode_cases();
    test_mode_switch();
    test_random_traffic();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && coded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (coded_q.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, coded_q.size());
      end
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
